>>> hw/rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT_AT  = 3'd4,
    KIND_REMOVE_AT  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_APPLY
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic en;
    op_t  op;
  } cell_cmd_t;

endpackage

>>> hw/rtl/ple_if.sv
// Request and response channel interfaces of the positional list engine.
interface ple_in_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     removed;
  logic                     dropped;
  logic [COUNT_W-1:0]       element_count;

  modport source (output valid, popped_value, removed, dropped, element_count, input ready);
  modport sink   (input valid, popped_value, removed, dropped, element_count, output ready);
endinterface

>>> hw/rtl/ple_cell.sv
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
module ple_cell import ple_pkg::*; #(
  parameter int unsigned IW = 8
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IW-1:0]     my_index,
  input  logic [IW-1:0]     idx,
  input  logic [DATA_W-1:0] new_value,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] leaf
);

  logic [DATA_W-1:0] data_r;
  logic              at_idx;
  logic              past_idx;

  assign at_idx   = (my_index == idx);
  assign past_idx = (my_index > idx);

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      case (cmd.op)
        OP_INS: begin
          if (at_idx) begin
            data_r <= new_value;
          end else if (past_idx) begin
            data_r <= prev_data;
          end
        end
        OP_DEL: begin
          if (at_idx || past_idx) begin
            data_r <= next_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign data = data_r;
  // Offer own entry to the extraction tree only when selected
  assign leaf = at_idx ? data_r : '0;

endmodule

>>> hw/rtl/ple_or_tree.sv
// Registered OR tree that gathers the one selected cell entry.
module ple_or_tree import ple_pkg::*; #(
  parameter int unsigned N = 256
) (
  input  logic              clk,
  input  logic [DATA_W-1:0] leaves [N],
  output logic [DATA_W-1:0] root
);

  localparam int unsigned LG = $clog2(N);
  localparam int unsigned P  = 1 << LG;

  logic [DATA_W-1:0] node_r [P-1];
  logic [DATA_W-1:0] kid    [2*P-1];

  for (genvar n = 0; n < 2*P-1; n++) begin : g_kid
    if (n < P-1) begin : g_inner
      assign kid[n] = node_r[n];
    end else if (n - (P-1) < N) begin : g_leaf
      assign kid[n] = leaves[n-(P-1)];
    end else begin : g_pad
      assign kid[n] = '0;
    end
  end

  for (genvar n = 0; n < P-1; n++) begin : g_node
    always_ff @(posedge clk) begin
      node_r[n] <= kid[2*n+1] | kid[2*n+2];
    end
  end

  assign root = node_r[0];

endmodule

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: control, count and the cell chain.
// Sequence: push, insert, refused or empty requests go from idle straight to apply;
//   pop and remove first wait in the select state for the registered OR tree that
//   extracts the selected entry. Apply waits while the result slot is still full.
// One request at a time: a new request is taken only once the last one is applied.
// Reset (synchronous, rst_n low): count cleared, controller idle, no result pending.
//   Cell contents are not cleared; entries at or above the count are never read.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ple_in_if.sink     in_req,
  ple_out_if.source  out_rsp
);

  // Widths: count holds 0..CAPACITY, index addresses one cell
  localparam int unsigned CW      = $clog2(CAPACITY + 1);
  localparam int unsigned IW      = $clog2(CAPACITY);
  localparam int unsigned PW      = (CW > POS_W - 1) ? CW : POS_W - 1;
  localparam int unsigned TREE_LAT = $clog2(CAPACITY);
  localparam int unsigned WW      = $clog2(TREE_LAT + 1);

  // Controller state
  state_t        state_r, state_nxt;
  logic [WW-1:0] wait_r,  wait_nxt;
  logic [CW-1:0] cnt_r,   cnt_nxt;

  // Held request
  op_t               op_r;
  logic [IW-1:0]     idx_r;
  logic [DATA_W-1:0] val_r;
  logic              rem_r;
  logic              drop_r;

  // Decoded request
  op_t           op_d;
  logic [IW-1:0] idx_d;
  logic          rem_d;
  logic          drop_d;

  // Result register
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_popped_r;
  logic               out_removed_r;
  logic               out_dropped_r;
  logic [COUNT_W-1:0] out_count_r;

  logic accept;
  logic apply_go;
  logic wait_done;
  logic full;
  logic pos_le0;
  logic pos_lt_cnt;
  logic [POS_W-2:0] pos_u;

  // Chain wiring
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_q    [CAPACITY];
  logic [DATA_W-1:0] cell_leaf [CAPACITY];
  logic [DATA_W-1:0] tree_root;

  kind_t kind_w;

  assign kind_w    = kind_t'(in_req.kind);
  assign accept    = in_req.valid && in_req.ready;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign pos_u     = in_req.position[POS_W-2:0];
  assign pos_le0   = in_req.position[POS_W-1] || (in_req.position == '0);
  assign pos_lt_cnt = (PW'(pos_u) < PW'(cnt_r));
  assign wait_done = (wait_r == WW'(TREE_LAT - 1));

  // Decode the request into a chain command and the target cell
  always_comb begin
    op_d   = OP_NONE;
    idx_d  = '0;
    rem_d  = 1'b0;
    drop_d = 1'b0;
    unique case (kind_w) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
        if (full) begin
          drop_d = 1'b1;
        end else begin
          op_d = OP_INS;
          if (kind_w == KIND_PUSH_FRONT) begin
            idx_d = '0;
          end else if (kind_w == KIND_PUSH_BACK) begin
            idx_d = IW'(cnt_r);
          end else if (pos_le0) begin
            idx_d = '0;
          end else if (pos_lt_cnt) begin
            idx_d = IW'(pos_u);
          end else begin
            idx_d = IW'(cnt_r);
          end
        end
      end
      KIND_POP_FRONT: begin
        if (cnt_r != '0) begin
          op_d  = OP_DEL;
          rem_d = 1'b1;
          idx_d = '0;
        end
      end
      KIND_POP_BACK: begin
        if (cnt_r != '0) begin
          op_d  = OP_DEL;
          rem_d = 1'b1;
          idx_d = IW'(cnt_r - CW'(1));
        end
      end
      KIND_REMOVE_AT: begin
        // Nothing taken when empty or when the position is past the last entry
        if (cnt_r != '0) begin
          if (pos_le0) begin
            op_d  = OP_DEL;
            rem_d = 1'b1;
            idx_d = '0;
          end else if (pos_lt_cnt) begin
            op_d  = OP_DEL;
            rem_d = 1'b1;
            idx_d = IW'(pos_u);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state: removals wait for the extraction tree to settle
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (op_d == OP_DEL) ? ST_SEL : ST_APPLY;
        end
      end
      ST_SEL: begin
        if (wait_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs: take requests only when idle, apply once the result slot is free
  always_comb begin
    in_req.ready = 1'b0;
    apply_go     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_req.ready = 1'b1;
      ST_SEL:   apply_go     = 1'b0;
      ST_APPLY: apply_go     = !out_valid_r || out_rsp.ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    wait_nxt = wait_r;
    if (accept) begin
      wait_nxt = '0;
    end else if (state_r == ST_SEL) begin
      wait_nxt = wait_r + WW'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (apply_go) begin
      if (op_r == OP_INS) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (op_r == OP_DEL) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      cnt_r   <= cnt_nxt;
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the decoded request until it is applied
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_d;
      idx_r  <= idx_d;
      val_r  <= in_req.value;
      rem_r  <= rem_d;
      drop_r <= drop_d;
    end
  end

  // Load the result as the chain shifts
  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_popped_r  <= rem_r ? tree_root : '0;
      out_removed_r <= rem_r;
      out_dropped_r <= drop_r;
      out_count_r   <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.popped_value  = out_popped_r;
  assign out_rsp.removed       = out_removed_r;
  assign out_rsp.dropped       = out_dropped_r;
  assign out_rsp.element_count = out_count_r;

  assign cmd.en = apply_go;
  assign cmd.op = op_r;

  // Cell chain: cell 0 is the front; inserts shift toward the back, removals toward the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_q[i+1];
    end

    ple_cell #(
      .IW (IW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_index  (IW'(i)),
      .idx       (idx_r),
      .new_value (val_r),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_q[i]),
      .leaf      (cell_leaf[i])
    );
  end

  // Gather the selected entry over clog2(CAPACITY) registered levels
  ple_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaves (cell_leaf),
    .root   (tree_root)
  );

  // Count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // A removal applied lowers the count by exactly one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && op_r == OP_DEL) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("removal did not lower the count");

  // A refused request only happens on a full store and leaves it full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && drop_r) |-> (full && op_r == OP_NONE))
    else $error("drop without a full store");

  // Never both taken out and refused in one result
  a_rem_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_removed_r && out_dropped_r))
    else $error("result both removed and dropped");

endmodule

>>> verif/tb_positional_list_engine.sv
// Self-checking testbench for the positional list engine with its own list predictor.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int unsigned LIST_DEPTH    = 256;
  // Hold the idle-cycle limit well above the longest legal silence: one long
  // receiver hold-off plus the slowest remove and a few idle bursts.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD_AT  = 60;
  localparam int unsigned LONG_HOLD_LEN = 80;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned MAX_REPORTS   = 10;

  // Kind codes that the package leaves unassigned; the block treats them as no-ops.
  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  // Request mixes for the random part.
  localparam int unsigned MIX_BALANCED = 0;
  localparam int unsigned MIX_GROW     = 1;
  localparam int unsigned MIX_SHRINK   = 2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     removed;
    logic                     dropped;
    logic [COUNT_W-1:0]       element_count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  ple_in_if  in_req ();
  ple_out_if out_rsp ();

  positional_list_engine #(
    .CAPACITY (LIST_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // Predicted list contents, front at index 0, and its length.
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len = 0;

  list_req_t   pending_req_q [$];
  list_rsp_t   expected_rsp_q [$];
  list_req_t   cur_req;

  int unsigned n_queued    = 0;
  int unsigned n_checked   = 0;
  int unsigned err_cnt     = 0;
  int unsigned drv_gap     = 0;
  int unsigned rcv_gap     = 0;
  int unsigned hold_left   = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done   = 1'b0;
  bit          quiet       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predicted list and work out the response it gives.
  task automatic apply_list_op(input list_req_t rq, output list_rsp_t rs);
    int  idx;
    int  i;
    logic full;
    rs   = '0;
    idx  = -1;
    full = (list_len >= LIST_DEPTH);
    case (rq.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
        if (full) begin
          // A full list refuses the insert and stays as it is.
          rs.dropped = 1'b1;
        end else begin
          if (rq.kind == KIND_PUSH_FRONT) begin
            idx = 0;
          end else if (rq.kind == KIND_PUSH_BACK) begin
            idx = list_len;
          end else if (rq.position <= 0) begin
            idx = 0;
          end else if (int'(rq.position) < list_len) begin
            idx = int'(rq.position);
          end else begin
            idx = list_len;
          end
          // Shift the entries behind the slot up by one, then fill the slot.
          for (i = list_len; i > idx; i--) begin
            list_mem[i] = list_mem[i-1];
          end
          list_mem[idx] = rq.value;
          list_len++;
          idx = -1;
        end
      end
      KIND_POP_FRONT: begin
        if (list_len > 0) idx = 0;
      end
      KIND_POP_BACK: begin
        if (list_len > 0) idx = list_len - 1;
      end
      KIND_REMOVE_AT: begin
        // At or below zero takes the front; at or past the count takes nothing.
        if (list_len > 0) begin
          if (rq.position <= 0) begin
            idx = 0;
          end else if (int'(rq.position) < list_len) begin
            idx = int'(rq.position);
          end
        end
      end
      default: begin
      end
    endcase
    if (idx >= 0) begin
      rs.popped_value = list_mem[idx];
      rs.removed      = 1'b1;
      for (i = idx; i + 1 < list_len; i++) begin
        list_mem[i] = list_mem[i+1];
      end
      list_len--;
    end
    rs.element_count = COUNT_W'(list_len);
  endtask

  task automatic queue_request(input logic [KIND_W-1:0] kind,
                               input logic signed [POS_W-1:0] position,
                               input logic signed [DATA_W-1:0] value);
    list_req_t rq;
    rq.kind     = kind;
    rq.position = position;
    rq.value    = value;
    pending_req_q.insert(pending_req_q.size(), rq);
    n_queued++;
  endtask

  // Build a random request; the mix decides how the list tends to move.
  function automatic list_req_t make_request(input int unsigned mix);
    list_req_t   rq;
    int unsigned roll;
    roll        = $urandom_range(0, 99);
    rq.value    = $urandom;
    rq.position = POS_W'($urandom);
    case (mix)
      MIX_GROW: begin
        // Only growing kinds, so the list is sure to fill and then refuse.
        if (roll < 40)      rq.kind = KIND_INSERT_AT;
        else if (roll < 70) rq.kind = KIND_PUSH_FRONT;
        else                rq.kind = KIND_PUSH_BACK;
      end
      MIX_SHRINK: begin
        if (roll < 30)      rq.kind = KIND_POP_FRONT;
        else if (roll < 55) rq.kind = KIND_POP_BACK;
        else if (roll < 90) rq.kind = KIND_REMOVE_AT;
        else if (roll < 96) rq.kind = KIND_PUSH_BACK;
        else                rq.kind = KIND_UNUSED_6;
      end
      default: begin
        if (roll < 15)      rq.kind = KIND_PUSH_FRONT;
        else if (roll < 30) rq.kind = KIND_PUSH_BACK;
        else if (roll < 42) rq.kind = KIND_POP_FRONT;
        else if (roll < 54) rq.kind = KIND_POP_BACK;
        else if (roll < 75) rq.kind = KIND_INSERT_AT;
        else if (roll < 96) rq.kind = KIND_REMOVE_AT;
        else if (roll < 98) rq.kind = KIND_UNUSED_6;
        else                rq.kind = KIND_UNUSED_7;
      end
    endcase
    // Keep most positions near the live range; the rest exercise every bit.
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      rq.position = POS_W'($urandom_range(0, 270));
    end else if (roll < 8) begin
      rq.position = POS_W'(-int'($urandom_range(1, 3)));
    end
    // Hit the value extremes now and then.
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       rq.value = 32'sh8000_0000;
        1:       rq.value = 32'sh7FFF_FFFF;
        2:       rq.value = '0;
        default: rq.value = '1;
      endcase
    end
    return rq;
  endfunction

  task automatic queue_random(input int unsigned count, input int unsigned mix);
    int unsigned k;
    list_req_t   rq;
    for (k = 0; k < count; k++) begin
      rq = make_request(mix);
      pending_req_q.insert(pending_req_q.size(), rq);
      n_queued++;
    end
  endtask

  // Hold the sender off until every outstanding response is back.
  task automatic wait_list_idle();
    wait (n_checked == n_queued);
    @(negedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next request or idle for a burst.
  always @(posedge clk) begin
    list_rsp_t rsp;
    if (!rst_n) begin
      in_req.valid    <= 1'b0;
      in_req.kind     <= '0;
      in_req.position <= '0;
      in_req.value    <= '0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        apply_list_op(cur_req, rsp);
        expected_rsp_q.insert(expected_rsp_q.size(), rsp);
      end
      if (!in_req.valid || in_req.ready) begin
        if (drv_gap > 0) begin
          drv_gap = drv_gap - 1;
          in_req.valid <= 1'b0;
        end else if (pending_req_q.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
          cur_req = pending_req_q[0];
          pending_req_q.delete(0);
          in_req.valid    <= 1'b1;
          in_req.kind     <= cur_req.kind;
          in_req.position <= cur_req.position;
          in_req.value    <= cur_req.value;
        end else begin
          // Idle now; if requests remain, start a random idle burst that includes this cycle.
          if (pending_req_q.size() > 0) drv_gap = $urandom_range(0, 2);
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response against the oldest prediction, then pace ready.
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected response: popped=%0d removed=%0b dropped=%0b count=%0d",
                     out_rsp.popped_value, out_rsp.removed, out_rsp.dropped,
                     out_rsp.element_count);
        end else begin
          want = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          n_checked++;
          if (out_rsp.popped_value !== want.popped_value ||
              out_rsp.removed !== want.removed ||
              out_rsp.dropped !== want.dropped ||
              out_rsp.element_count !== want.element_count) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display({"mismatch on response %0d: exp popped=%0d removed=%0b dropped=%0b",
                        " count=%0d, got popped=%0d removed=%0b dropped=%0b count=%0d"},
                       n_checked, want.popped_value, want.removed, want.dropped,
                       want.element_count, out_rsp.popped_value, out_rsp.removed,
                       out_rsp.dropped, out_rsp.element_count);
          end
        end
      end
      // Hold ready low once for a long stretch so the block backs up into its input.
      if (!hold_done && n_checked >= LONG_HOLD_AT) begin
        hold_left = LONG_HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_rsp.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap = rcv_gap - 1;
        out_rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rcv_gap = $urandom_range(0, 2);
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;

    // Directed: empty-list pops and removes, front/back/middle inserts and
    // removes, out-of-range positions and the unused kinds.
    queue_request(KIND_POP_FRONT, 16'sd0, 32'sd0);
    queue_request(KIND_POP_BACK, 16'sd0, 32'sd0);
    queue_request(KIND_REMOVE_AT, 16'sd0, 32'sd0);
    queue_request(KIND_REMOVE_AT, 16'sh8000, 32'sd0);
    queue_request(KIND_UNUSED_6, 16'sh7FFF, 32'sh7FFF_FFFF);
    queue_request(KIND_PUSH_FRONT, 16'sd0, 32'sh7FFF_FFFF);
    queue_request(KIND_PUSH_BACK, 16'sd0, 32'sh8000_0000);
    queue_request(KIND_INSERT_AT, 16'sh8000, 32'sd0);
    queue_request(KIND_INSERT_AT, 16'sh7FFF, -32'sd1);
    queue_request(KIND_INSERT_AT, 16'sd2, 32'sh1234_5678);
    queue_request(KIND_INSERT_AT, 16'sd0, 32'sh5A5A_A5A5);
    queue_request(KIND_PUSH_FRONT, 16'sh7FFF, 32'sd99);
    queue_request(KIND_REMOVE_AT, 16'sh7FFF, 32'sd0);
    queue_request(KIND_REMOVE_AT, 16'sd7, 32'sd0);
    queue_request(KIND_REMOVE_AT, 16'sd3, 32'sd0);
    queue_request(KIND_REMOVE_AT, -16'sd1, 32'sd0);
    queue_request(KIND_REMOVE_AT, 16'sd0, 32'sd0);
    queue_request(KIND_UNUSED_7, 16'sh8000, 32'sh8000_0000);
    queue_request(KIND_POP_BACK, 16'sd0, 32'sd0);
    queue_request(KIND_INSERT_AT, 16'sd1, 32'sh0F0F_0F0F);
    queue_request(KIND_REMOVE_AT, 16'sd1, 32'sd0);
    queue_request(KIND_POP_FRONT, 16'sd0, 32'sd0);
    queue_request(KIND_POP_FRONT, 16'sd0, 32'sd0);
    queue_request(KIND_POP_BACK, 16'sd0, 32'sd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Pause the sender until the directed part has fully drained.
    wait_list_idle();

    // Random: mixed traffic, then fill past capacity, churn while full, shrink.
    queue_random(50, MIX_BALANCED);
    queue_random(270, MIX_GROW);
    queue_random(20, MIX_BALANCED);
    queue_random(50, MIX_SHRINK);

    // Pause again, then finish with a stretch that has no idling on either side.
    wait_list_idle();
    quiet = 1'b1;
    queue_random(36, MIX_BALANCED);

    wait_list_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
